>>> hdl/btr_pkg.sv
// ============================================================================
// btr_pkg
// Shared constants, codes and helpers for the bitmap text renderer.
// ============================================================================
package btr_pkg;

    // Font memory: depth is a power of two, addresses wrap by truncation.
    localparam int FONT_MEM_DEPTH   = 8192;
    localparam int FONT_AW          = $clog2(FONT_MEM_DEPTH);
    localparam int MAX_GLYPH_WIDTH  = 16;
    localparam int MAX_GLYPH_HEIGHT = 32;
    localparam int ROW_W            = $clog2(MAX_GLYPH_HEIGHT);
    localparam int COORD_BITS       = 12;

    // Configuration port.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Register indexes.
    localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd0;
    localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd1;
    localparam logic [2:0] REG_FRONT_COLOR  = 3'd2;
    localparam logic [2:0] REG_BACK_COLOR   = 3'd3;
    localparam logic [2:0] REG_BACK_ENABLE  = 3'd4;
    localparam logic [2:0] REG_SCREEN_WIDTH = 3'd5;
    localparam logic [2:0] REG_LEFT_MARGIN  = 3'd6;

    // Actions.
    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_CURSOR = 2'd1;
    localparam logic [1:0] ACT_PRINT  = 2'd2;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    typedef logic [COORD_BITS-1:0] t_coord;

    // Latin-1 to codepage 437 for the few glyphs that differ.
    function automatic logic [7:0] remap_code(input logic [7:0] code);
        logic [7:0] r;
        unique case (code)
            8'hF6:   r = 8'h94;
            8'hD6:   r = 8'h99;
            8'hFC:   r = 8'h81;
            8'hDC:   r = 8'h9A;
            8'hE4:   r = 8'h84;
            8'hC4:   r = 8'h8E;
            8'hB5:   r = 8'hE6;
            8'hB0:   r = 8'hF8;
            default: r = code;
        endcase
        return r;
    endfunction

    // Low n bits set, n in 0..8.
    function automatic logic [7:0] seg_mask(input logic [3:0] n);
        logic [8:0] t;
        t = (9'd1 << n) - 9'd1;
        return t[7:0];
    endfunction

endpackage

>>> hdl/btr_ram.sv
// ============================================================================
// btr_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module btr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/bitmap_text_renderer.sv
// ============================================================================
// bitmap_text_renderer
// Bitmap font character generator with a text cursor.
// ============================================================================
// Usage
//   Input channel (i_valid / o_stall): one beat is one action. A load writes
//   i_font_data at i_font_address into the font memory; a set-cursor moves
//   the cursor; a print draws i_character at the cursor and advances it.
//   Output channel (o_valid / i_stall): one beat per font byte of the glyph,
//   rows top to bottom, bytes left to right, o_last on the final one.
//   Configuration: APB-style register port, registers at 4*index.
// Timing
//   Load and set-cursor leave o_stall low. A print runs through the steps:
//   compute the glyph base address (one small multiply), read each font
//   byte through the single read port of the font memory, then advance
//   the cursor (add, then add and compare). Each segment passes the read
//   stage and the output register. bpr is 1 for widths up to 8, 2 above.
// Stall
//   The output register holds while i_stall is high; the memory read stage
//   behind it holds too, and the byte sequencer waits. o_stall stays high
//   for the whole print. An already finished segment may still wait at the
//   output while the next action is taken.
// Reset: synchronous, active low; registers take their defaults, cursor is
//   zero, pipeline empties. The font memory is not cleared.
// ============================================================================
module bitmap_text_renderer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input items
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_action,
    input  logic [12:0]                   i_font_address,
    input  logic [7:0]                    i_font_data,
    input  logic [7:0]                    i_character,
    input  logic [11:0]                   i_cursor_col,
    input  logic [11:0]                   i_cursor_line,
    // result items
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [11:0]                   o_pos_x,
    output logic [11:0]                   o_pos_y,
    output logic [7:0]                    o_fg_mask,
    output logic [7:0]                    o_bg_mask,
    output logic [15:0]                   o_fg_color,
    output logic [15:0]                   o_bg_color,
    output logic                          o_last,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [btr_pkg::PADDR_W-1:0]   paddr,
    input  logic [btr_pkg::PDATA_W-1:0]   pwdata,
    output logic [btr_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import btr_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADDR = 3'd1;  // base address multiply
    localparam logic [2:0] S_RUN  = 3'd2;  // one font byte read per cycle unless the output stalls
    localparam logic [2:0] S_ADV1 = 3'd3;  // x += width
    localparam logic [2:0] S_ADV2 = 3'd4;  // wrap test

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [4:0]  r_glyph_width;
    logic [5:0]  r_glyph_height;
    logic [15:0] r_front_color;
    logic [15:0] r_back_color;
    logic        r_back_enable;
    t_coord      r_screen_width;
    t_coord      r_left_margin;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_width  <= 5'd8;
            r_glyph_height <= 6'd16;
            r_front_color  <= 16'hFFFF;
            r_back_color   <= 16'h0000;
            r_back_enable  <= 1'b0;
            r_screen_width <= t_coord'(320);
            r_left_margin  <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_GLYPH_WIDTH:  r_glyph_width  <= pwdata[4:0];
                REG_GLYPH_HEIGHT: r_glyph_height <= pwdata[5:0];
                REG_FRONT_COLOR:  r_front_color  <= pwdata[15:0];
                REG_BACK_COLOR:   r_back_color   <= pwdata[15:0];
                REG_BACK_ENABLE:  r_back_enable  <= pwdata[0];
                REG_SCREEN_WIDTH: r_screen_width <= pwdata[COORD_BITS-1:0];
                REG_LEFT_MARGIN:  r_left_margin  <= pwdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_GLYPH_WIDTH:  prdata = PDATA_W'(r_glyph_width);
            REG_GLYPH_HEIGHT: prdata = PDATA_W'(r_glyph_height);
            REG_FRONT_COLOR:  prdata = PDATA_W'(r_front_color);
            REG_BACK_COLOR:   prdata = PDATA_W'(r_back_color);
            REG_BACK_ENABLE:  prdata = PDATA_W'(r_back_enable);
            REG_SCREEN_WIDTH: prdata = PDATA_W'(r_screen_width);
            REG_LEFT_MARGIN:  prdata = PDATA_W'(r_left_margin);
            default:          prdata = '0;
        endcase
    end

    // Saturated glyph geometry; config must stay static while a print runs (not enforced here).
    logic [4:0] w_eff;
    logic [5:0] h_eff;
    logic [5:0] h_m1;
    logic       wide;        // two bytes per row
    logic       empty_glyph;
    logic [7:0] mask_c0;
    logic [7:0] mask_c1;

    assign w_eff       = (r_glyph_width > 5'(MAX_GLYPH_WIDTH)) ?
                         5'(MAX_GLYPH_WIDTH) : r_glyph_width;
    assign h_eff       = (r_glyph_height > 6'(MAX_GLYPH_HEIGHT)) ?
                         6'(MAX_GLYPH_HEIGHT) : r_glyph_height;
    assign h_m1        = h_eff - 6'd1;
    assign wide        = (w_eff > 5'd8);
    assign empty_glyph = (w_eff == 5'd0) || (h_eff == 6'd0);
    assign mask_c0     = seg_mask(wide ? 4'd8 : w_eff[3:0]);
    assign mask_c1     = seg_mask(4'(w_eff - 5'd8));

    // ------------------------------------------------------------------
    // Sequencer and cursor
    // ------------------------------------------------------------------
    logic [2:0]       r_state;
    logic [2:0]       n_state;
    t_coord           r_cur_x;
    t_coord           r_cur_y;
    logic [7:0]       r_code;
    logic             r_newline;
    logic [FONT_AW-1:0] r_addr;
    logic [ROW_W-1:0] r_row;
    logic             r_col;

    logic in_acc;
    logic out_free;
    logic issue;
    logic seg_last;
    logic [13:0] code_x_h;   // full code * height, up to 255 * 32
    logic [14:0] base_prod;

    // read stage and output register
    logic         r_pend;
    t_coord       r_p_x;
    t_coord       r_p_y;
    logic [7:0]   r_p_mask;
    logic         r_p_last;
    logic [7:0]   ram_rdata;
    logic         out_load;
    logic         r_o_valid;

    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;
    assign issue    = (r_state == S_RUN) && (!r_pend || out_free);
    assign out_load = r_pend && out_free;
    assign seg_last = ({1'b0, r_row} == h_m1) && (r_col || !wide);

    // code * height * bytes_per_row, wrapped to the memory depth
    assign code_x_h  = 14'(r_code) * 14'(h_eff);
    assign base_prod = wide ? {code_x_h, 1'b0} : {1'b0, code_x_h};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc && i_action == ACT_PRINT) n_state = S_ADDR;
            S_ADDR: n_state = empty_glyph ? S_ADV1 : S_RUN;
            S_RUN:  if (issue && seg_last) n_state = S_ADV1;
            S_ADV1: n_state = S_ADV2;
            S_ADV2: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cur_x <= '0;
            r_cur_y <= '0;
        end else begin
            r_state <= n_state;
            if (in_acc && i_action == ACT_CURSOR) begin
                r_cur_x <= i_cursor_col;
                r_cur_y <= i_cursor_line;
            end
            if (r_state == S_ADV1) begin
                r_cur_x <= r_cur_x + t_coord'(w_eff);
            end
            if (r_state == S_ADV2) begin
                if (({1'b0, r_cur_x} + (COORD_BITS+1)'(w_eff)) >
                    {1'b0, r_screen_width} || r_newline) begin
                    r_cur_x <= r_left_margin;
                    r_cur_y <= r_cur_y + t_coord'(h_eff);
                end
            end
        end
    end

    // glyph walk: byte address, row and column counters
    always_ff @(posedge i_clk) begin
        if (in_acc && i_action == ACT_PRINT) begin
            r_code    <= remap_code(i_character);
            r_newline <= (i_character == CHAR_NEWLINE);
        end
        if (r_state == S_ADDR) begin
            r_addr <= base_prod[FONT_AW-1:0];
            r_row  <= '0;
            r_col  <= 1'b0;
        end else if (issue) begin
            r_addr <= r_addr + FONT_AW'(1);
            if (wide && !r_col) begin
                r_col <= 1'b1;
            end else begin
                r_col <= 1'b0;
                r_row <= r_row + ROW_W'(1);
            end
        end
    end

    btr_ram #(
        .WIDTH (8),
        .DEPTH (FONT_MEM_DEPTH)
    ) u_font_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && i_action == ACT_LOAD),
        .i_waddr (i_font_address[FONT_AW-1:0]),
        .i_wdata (i_font_data),
        .i_re    (issue),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // segment tags travel alongside the read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= issue || (r_pend && !out_free);
        end
        if (issue) begin
            r_p_x    <= r_cur_x + t_coord'({r_col, 3'b000});
            r_p_y    <= r_cur_y + t_coord'(r_row);
            r_p_mask <= r_col ? mask_c1 : mask_c0;
            r_p_last <= seg_last;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= out_load || (r_o_valid && i_stall);
        end
        if (out_load) begin
            o_pos_x   <= r_p_x;
            o_pos_y   <= r_p_y;
            o_fg_mask <= ram_rdata & r_p_mask;
            o_bg_mask <= r_back_enable ? (~ram_rdata & r_p_mask) : 8'h00;
            o_last    <= r_p_last;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_fg_color = r_front_color;
    assign o_bg_color = r_back_color;

endmodule

>>> hdl/btr_checker.sv
// ============================================================================
// btr_checker
// Port-level assertions for the bitmap text renderer.
// ============================================================================
module btr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [1:0]  i_action,
    input logic        o_valid,
    input logic        i_stall,
    input logic [11:0] o_pos_x,
    input logic [11:0] o_pos_y,
    input logic [7:0]  o_fg_mask,
    input logic [7:0]  o_bg_mask
);
    import btr_pkg::*;

    // output empties on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // a print keeps the input side busy on the next cycle
    a_print_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_action == ACT_PRINT) |=> o_stall)
        else $error("print beat not followed by busy");

    // a pixel is never both foreground and background
    a_mask_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_fg_mask & o_bg_mask) == 8'h00))
        else $error("fg and bg masks overlap");

    // stalled segment holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_pos_x) &&
                                  $stable(o_pos_y) && $stable(o_fg_mask)))
        else $error("stalled beat changed");

endmodule

bind bitmap_text_renderer btr_checker u_btr_checker (.*);
